### rtl/core/cfe_pkg.sv
// Shared types, constants and helpers for the clipped rectangle fill engine.
package cfe_pkg;

	localparam int SCREEN_WIDTH  = 160;
	localparam int SCREEN_HEIGHT = 128;
	localparam int PIXELS        = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int COL_W         = $clog2(SCREEN_WIDTH);
	localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
	localparam int ADDR_W        = $clog2(PIXELS);
	localparam int CLIP_W        = 16;

	localparam int PERMILLE_FULL = 1000;
	localparam int PM_W          = 10;
	localparam int SPAN_W        = 11;
	localparam int PROD_W        = SPAN_W + PM_W;
	localparam int RECIP_SHIFT   = 30;
	localparam int RECIP_W       = 21;
	localparam int RECIP         = ((2 ** RECIP_SHIFT) + PERMILLE_FULL - 1) / PERMILLE_FULL;

	localparam logic [2:0] KIND_FILL_SCREEN = 3'd0;
	localparam logic [2:0] KIND_FILL_RECT   = 3'd1;
	localparam logic [2:0] KIND_OUTLINE     = 3'd2;
	localparam logic [2:0] KIND_PROGRESS    = 3'd3;
	localparam logic [2:0] KIND_READ        = 3'd4;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [11:0] pos_x;
		logic signed [11:0] pos_y;
		logic signed [11:0] rect_width;
		logic signed [11:0] rect_height;
		logic [9:0]         fill_permille;
		logic [15:0]        fg_color;
		logic [15:0]        bg_color;
	} cmd_t;

	typedef struct packed {
		logic [15:0] pixel_value;
		logic        drew_nothing;
	} result_t;

	typedef enum logic [3:0] {
		BOX_NONE,
		BOX_CLEAR,
		BOX_FULL,
		BOX_MAIN,
		BOX_TOP,
		BOX_BOTTOM,
		BOX_LEFT,
		BOX_RIGHT,
		BOX_BAR
	} box_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RUN,
		ST_IDLE,
		ST_READ,
		ST_READ_CAP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic latch;
		logic box_load;
		logic box_step;
		logic rd_issue;
		logic rd_capture;
		box_t box;
	} dp_cmd_t;

	typedef struct packed {
		logic box_empty;
		logic box_last;
	} dp_stat_t;

	function automatic box_t next_box(box_t b, logic [2:0] kind);
		box_t n;
		case (b)
			BOX_MAIN:   n = (kind == KIND_PROGRESS) ? BOX_BAR : BOX_NONE;
			BOX_TOP:    n = BOX_BOTTOM;
			BOX_BOTTOM: n = BOX_LEFT;
			BOX_LEFT:   n = BOX_RIGHT;
			default:    n = BOX_NONE;
		endcase
		return n;
	endfunction

endpackage

### rtl/core/cfe_ctrl.sv
// Command sequencer: walks the strips of each command and the clearing pass.
module cfe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2:0]        kind,
	input  cfe_pkg::dp_stat_t dp_stat,
	output cfe_pkg::dp_cmd_t  dp_cmd,
	output logic              busy,
	output logic              done
);

	cfe_pkg::state_t state_q, state_d;
	cfe_pkg::box_t   box_q, box_d, box_nx;
	cfe_pkg::state_t fin_state;
	logic [2:0]      kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfe_pkg::ST_LOAD;
			box_q   <= cfe_pkg::BOX_CLEAR;
			kind_q  <= cfe_pkg::KIND_FILL_SCREEN;
		end else begin
			state_q <= state_d;
			box_q   <= box_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		dp_cmd    = '0;
		state_d   = state_q;
		box_d     = box_q;
		kind_d    = kind_q;
		busy      = 1'b1;
		done      = 1'b0;
		box_nx    = cfe_pkg::next_box(box_q, kind_q);
		fin_state = (box_q == cfe_pkg::BOX_CLEAR) ? cfe_pkg::ST_IDLE : cfe_pkg::ST_DONE;
		case (state_q)
			cfe_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					dp_cmd.latch = 1'b1;
					kind_d       = kind;
					case (kind)
						cfe_pkg::KIND_FILL_SCREEN: begin
							box_d   = cfe_pkg::BOX_FULL;
							state_d = cfe_pkg::ST_LOAD;
						end
						cfe_pkg::KIND_FILL_RECT, cfe_pkg::KIND_PROGRESS: begin
							box_d   = cfe_pkg::BOX_MAIN;
							state_d = cfe_pkg::ST_LOAD;
						end
						cfe_pkg::KIND_OUTLINE: begin
							box_d   = cfe_pkg::BOX_TOP;
							state_d = cfe_pkg::ST_LOAD;
						end
						cfe_pkg::KIND_READ: state_d = cfe_pkg::ST_READ;
						default:            state_d = cfe_pkg::ST_DONE;
					endcase
				end
			end
			cfe_pkg::ST_LOAD: begin
				dp_cmd.box_load = 1'b1;
				dp_cmd.box      = box_q;
				if (dp_stat.box_empty) begin
					box_d = box_nx;
					if (box_nx == cfe_pkg::BOX_NONE) state_d = fin_state;
				end else begin
					state_d = cfe_pkg::ST_RUN;
				end
			end
			cfe_pkg::ST_RUN: begin
				dp_cmd.box_step = 1'b1;
				if (dp_stat.box_last) begin
					box_d   = box_nx;
					state_d = (box_nx == cfe_pkg::BOX_NONE) ? fin_state : cfe_pkg::ST_LOAD;
				end
			end
			cfe_pkg::ST_READ: begin
				dp_cmd.rd_issue = 1'b1;
				state_d         = cfe_pkg::ST_READ_CAP;
			end
			cfe_pkg::ST_READ_CAP: begin
				dp_cmd.rd_capture = 1'b1;
				state_d           = cfe_pkg::ST_DONE;
			end
			cfe_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = cfe_pkg::ST_IDLE;
			end
			default: state_d = cfe_pkg::ST_IDLE;
		endcase
	end

endmodule

### rtl/core/cfe_datapath.sv
// Datapath: clipping, pixel walk, bar width, frame store and result registers.
module cfe_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  cfe_pkg::cmd_t     cmd,
	input  cfe_pkg::dp_cmd_t  dp_cmd,
	output cfe_pkg::dp_stat_t dp_stat,
	output cfe_pkg::result_t  result
);

	localparam int CW = cfe_pkg::CLIP_W;
	localparam int AW = cfe_pkg::ADDR_W;
	localparam int MW = cfe_pkg::PROD_W + cfe_pkg::RECIP_W;
	localparam logic signed [CW-1:0] SW_C = CW'(cfe_pkg::SCREEN_WIDTH);
	localparam logic signed [CW-1:0] SH_C = CW'(cfe_pkg::SCREEN_HEIGHT);
	localparam logic signed [CW-1:0] ONE  = CW'(1);
	localparam logic [AW-1:0] ROW_STRIDE  = AW'(cfe_pkg::SCREEN_WIDTH);

	function automatic logic signed [CW-1:0] sx(logic [11:0] v);
		return {{(CW-12){v[11]}}, v};
	endfunction

	cfe_pkg::cmd_t cmd_q;

	// bar width pipeline
	logic [cfe_pkg::SPAN_W-1:0] w_pos;
	logic [cfe_pkg::PM_W-1:0]   pm_c;
	logic [cfe_pkg::PROD_W-1:0] p_s1;
	logic [MW-1:0]              q_full;
	logic [cfe_pkg::SPAN_W-1:0] fw_s2;

	// clipping
	logic signed [CW-1:0] bx, by, bw, bh;
	logic signed [CW-1:0] x_lo, y_lo, x_end, y_end, x_hi, y_hi, x_last, y_last;
	logic                 empty;
	logic [15:0]          box_colour;
	logic [AW-1:0]        ld_addr;

	// pixel walk
	logic [cfe_pkg::COL_W-1:0] col_q, x0_q, xlast_q;
	logic [cfe_pkg::ROW_W-1:0] row_q, ylast_q;
	logic [AW-1:0]             addr_q, rowstart_q;
	logic [15:0]               colour_q;
	logic                      col_end, row_end;

	// read path
	logic [15:0]   mem [cfe_pkg::PIXELS];
	logic [15:0]   rd_q;
	logic [AW-1:0] rd_addr;
	logic          on_screen;
	logic          any_q;
	logic [15:0]   pixel_q;

	always_ff @(posedge clk) begin
		if (dp_cmd.latch) cmd_q <= cmd;
	end

	// product registered with the command, then scaled into the registered bar width fw_s2
	assign w_pos = ($signed(cmd.rect_width) > 12'sd0) ?
		cmd.rect_width[cfe_pkg::SPAN_W-1:0] : '0;
	assign pm_c = (cmd.fill_permille > cfe_pkg::PM_W'(cfe_pkg::PERMILLE_FULL)) ?
		cfe_pkg::PM_W'(cfe_pkg::PERMILLE_FULL) : cmd.fill_permille;
	assign q_full = MW'(p_s1) * MW'(cfe_pkg::RECIP);

	always_ff @(posedge clk) begin
		if (dp_cmd.latch) p_s1 <= cfe_pkg::PROD_W'(w_pos) * cfe_pkg::PROD_W'(pm_c);
		fw_s2 <= q_full[cfe_pkg::RECIP_SHIFT +: cfe_pkg::SPAN_W];
	end

	always_comb begin
		bx = sx(cmd_q.pos_x);
		by = sx(cmd_q.pos_y);
		bw = sx(cmd_q.rect_width);
		bh = sx(cmd_q.rect_height);
		box_colour = cmd_q.fg_color;
		case (dp_cmd.box)
			cfe_pkg::BOX_CLEAR, cfe_pkg::BOX_FULL: begin
				bx = '0;
				by = '0;
				bw = SW_C;
				bh = SH_C;
				if (dp_cmd.box == cfe_pkg::BOX_CLEAR) box_colour = '0;
			end
			cfe_pkg::BOX_MAIN: begin
				if (cmd_q.kind == cfe_pkg::KIND_PROGRESS) box_colour = cmd_q.bg_color;
			end
			cfe_pkg::BOX_TOP:    bh = ONE;
			cfe_pkg::BOX_BOTTOM: begin
				by = sx(cmd_q.pos_y) + sx(cmd_q.rect_height) - ONE;
				bh = ONE;
			end
			cfe_pkg::BOX_LEFT:   bw = ONE;
			cfe_pkg::BOX_RIGHT: begin
				bx = sx(cmd_q.pos_x) + sx(cmd_q.rect_width) - ONE;
				bw = ONE;
			end
			cfe_pkg::BOX_BAR:    bw = CW'(fw_s2);
			default: begin
				bw = '0;
				bh = '0;
			end
		endcase
		x_lo   = (bx < 0) ? '0 : bx;
		y_lo   = (by < 0) ? '0 : by;
		x_end  = bx + bw;
		y_end  = by + bh;
		x_hi   = (x_end > SW_C) ? SW_C : x_end;
		y_hi   = (y_end > SH_C) ? SH_C : y_end;
		x_last = x_hi - ONE;
		y_last = y_hi - ONE;
		empty  = (x_hi <= x_lo) || (y_hi <= y_lo);
		ld_addr = AW'(y_lo[cfe_pkg::ROW_W-1:0]) * ROW_STRIDE + AW'(x_lo[cfe_pkg::COL_W-1:0]);
	end

	assign col_end = (col_q == xlast_q);
	assign row_end = (row_q == ylast_q);

	always_ff @(posedge clk) begin
		if (dp_cmd.box_load) begin
			col_q      <= x_lo[cfe_pkg::COL_W-1:0];
			x0_q       <= x_lo[cfe_pkg::COL_W-1:0];
			xlast_q    <= x_last[cfe_pkg::COL_W-1:0];
			row_q      <= y_lo[cfe_pkg::ROW_W-1:0];
			ylast_q    <= y_last[cfe_pkg::ROW_W-1:0];
			addr_q     <= ld_addr;
			rowstart_q <= ld_addr;
			colour_q   <= box_colour;
		end else if (dp_cmd.box_step) begin
			if (col_end) begin
				col_q      <= x0_q;
				row_q      <= row_q + 1'b1;
				rowstart_q <= rowstart_q + ROW_STRIDE;
				addr_q     <= rowstart_q + ROW_STRIDE;
			end else begin
				col_q  <= col_q + 1'b1;
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	assign dp_stat.box_empty = empty;
	assign dp_stat.box_last  = col_end && row_end;

	assign on_screen = (sx(cmd_q.pos_x) >= 0) && (sx(cmd_q.pos_x) < SW_C) &&
		(sx(cmd_q.pos_y) >= 0) && (sx(cmd_q.pos_y) < SH_C);
	assign rd_addr = AW'(cmd_q.pos_y[cfe_pkg::ROW_W-1:0]) * ROW_STRIDE +
		AW'(cmd_q.pos_x[cfe_pkg::COL_W-1:0]);

	always_ff @(posedge clk) begin
		if (dp_cmd.box_step) mem[addr_q] <= colour_q;
		if (dp_cmd.rd_issue) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q   <= 1'b0;
			pixel_q <= '0;
		end else if (dp_cmd.latch) begin
			any_q   <= 1'b0;
			pixel_q <= '0;
		end else begin
			if (dp_cmd.box_load && !empty && dp_cmd.box != cfe_pkg::BOX_BAR &&
				dp_cmd.box != cfe_pkg::BOX_CLEAR) begin
				any_q <= 1'b1;
			end
			if (dp_cmd.rd_issue && on_screen) any_q <= 1'b1;
			if (dp_cmd.rd_capture) pixel_q <= any_q ? rd_q : '0;
		end
	end

	assign result.pixel_value  = pixel_q;
	assign result.drew_nothing = ~any_q;

endmodule

### rtl/core/clipped_rectangle_fill_engine_top.sv
// Top level of the clipped rectangle fill engine: sequencer plus datapath.
// A command is taken when start is high and busy is low; its one result beat
// appears on result with done high for a single cycle and cannot be stalled.
// After reset the 160x128 frame store is cleared one pixel per cycle, and busy
// stays high until the clearing pass ends. The frame store has one write port,
// so pixels are written one at a time, each strip after a set-up state: a
// full-screen fill writes every pixel; a clipped rectangle its clipped area; an
// outline its four one-pixel strips; a progress bar the background area and
// then the bar area. An empty strip writes nothing. A pixel read passes through
// the read-issue and read-capture states before its result beat.
module clipped_rectangle_fill_engine_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cfe_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done,
	output cfe_pkg::result_t result
);

	cfe_pkg::dp_cmd_t  dp_cmd;
	cfe_pkg::dp_stat_t dp_stat;

	cfe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.kind    (cmd.kind),
		.dp_stat (dp_stat),
		.dp_cmd  (dp_cmd),
		.busy    (busy),
		.done    (done)
	);

	cfe_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.dp_cmd  (dp_cmd),
		.dp_stat (dp_stat),
		.result  (result)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result beat without a command in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat held longer than one cycle");

	a_pixel_drawn: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.pixel_value != 16'd0) |-> !result.drew_nothing)
		else $error("nonzero pixel reported with drew_nothing set");

endmodule
